FILE: rtl/core/tfc_pkg.sv
package tfc_pkg;

	typedef enum logic [1:0] {
		OP_PUSH = 2'd0,
		OP_DONE = 2'd1,
		OP_READ = 2'd2
	} op_t;

	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;

	// one step of the ring control: a single byte write attempt, a done or another command
	typedef struct packed {
		logic       step;
		op_t        op;
		logic [7:0] ch;
		logic       eos;
		logic       last;
	} ctrl_cmd_t;

	typedef struct packed {
		logic       stored;
		logic       start;
		logic [9:0] run_start;
		logic [9:0] run_length;
	} ctrl_res_t;

endpackage

FILE: rtl/core/tx_ring_fifo_crlf_chunker_core.sv
// channel   | ports                                               | timing
// ----------+-----------------------------------------------------+-------------------------
// command   | start, busy, operation, data_byte, end_of_string,   | transfer at start & !busy
//           | read_index                                          |
// result    | done, bytes_stored, byte_dropped, start_transfer,   | valid while done is high
//           | run_start, run_length, read_data                    |
// config    | cfg_we, cfg_wdata (lf_to_crlf)                      | written when cfg_we high
//
// A command is registered and worked on there; its result is registered again onto done.
// A pushed line feed with translation on is handled as a CR phase, then an LF phase, as
// both go through the single write port of the byte store; busy is high in the CR phase.
// Every other command may be followed by a new one in the next cycle.
// Reset clears pointers and flags and sets lf_to_crlf; the byte store is not cleared.
// Results cannot be stalled: done is high for exactly one cycle per command.
module tx_ring_fifo_crlf_chunker_core #(
	parameter int FIFO_DEPTH = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] operation,
	input  logic [7:0] data_byte,
	input  logic       end_of_string,
	input  logic [9:0] read_index,
	output logic       done,
	output logic [1:0] bytes_stored,
	output logic       byte_dropped,
	output logic       start_transfer,
	output logic [9:0] run_start,
	output logic [9:0] run_length,
	output logic [7:0] read_data,
	input  logic       cfg_we,
	input  logic       cfg_wdata
);

	import tfc_pkg::*;

	localparam int AW = $clog2(FIFO_DEPTH);

	logic          xlate_q;
	logic          valid_s1;
	op_t           op_s1;
	logic [7:0]    byte_s1;
	logic          eos_s1;
	logic [9:0]    idx_s1;
	logic          phase2_q;
	logic          cr_stored_q;

	logic          accept, two_phase, last;
	ctrl_cmd_t     cmd;
	ctrl_res_t     res;
	logic          we;
	logic [AW-1:0] waddr;
	logic [7:0]    wdata;
	logic [AW+9:0] idx_ext;
	logic          rd_en;
	logic [7:0]    ram_rdata;

	logic          done_s2;
	logic [1:0]    bytes_s2;
	logic          drop_s2;
	logic          start_s2;
	logic [9:0]    rstart_s2;
	logic [9:0]    rlen_s2;
	logic          rd_ok_s2;

	assign accept    = start && !busy;
	assign two_phase = valid_s1 && (op_s1 == OP_PUSH) && xlate_q && (byte_s1 == CH_LF);
	assign busy      = two_phase && !phase2_q;
	assign last      = !two_phase || phase2_q;

	always_comb begin
		cmd.step = valid_s1;
		cmd.op   = op_s1;
		cmd.eos  = eos_s1;
		cmd.last = last;
		if (phase2_q) begin
			cmd.ch = CH_LF;
		end else if (two_phase) begin
			cmd.ch = CH_CR;
		end else begin
			cmd.ch = byte_s1;
		end
		idx_ext = {AW'(0), idx_s1};
		rd_en   = valid_s1 && (op_s1 == OP_READ) && (idx_ext < (AW+10)'(FIFO_DEPTH));
	end

	tfc_ring_ctrl #(
		.DEPTH (FIFO_DEPTH),
		.AW    (AW)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.res    (res),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata)
	);

	tfc_byte_ram #(
		.DEPTH (FIFO_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (rd_en),
		.raddr (idx_ext[AW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xlate_q  <= 1'b1;
			valid_s1 <= 1'b0;
			phase2_q <= 1'b0;
			done_s2  <= 1'b0;
		end else begin
			if (cfg_we) begin
				xlate_q <= cfg_wdata;
			end
			valid_s1 <= accept || busy;
			phase2_q <= busy;
			done_s2  <= valid_s1 && last;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= op_t'(operation);
			byte_s1 <= data_byte;
			eos_s1  <= end_of_string;
			idx_s1  <= read_index;
		end
		if (busy) begin
			cr_stored_q <= res.stored;
		end
		if (valid_s1 && last) begin
			start_s2  <= res.start;
			rstart_s2 <= res.start ? res.run_start : '0;
			rlen_s2   <= res.start ? res.run_length : '0;
			rd_ok_s2  <= rd_en;
			case (op_s1)
				OP_PUSH: begin
					drop_s2 <= !res.stored;
					if (two_phase) begin
						bytes_s2 <= {1'b0, cr_stored_q} + {1'b0, res.stored};
					end else begin
						bytes_s2 <= {1'b0, res.stored};
					end
				end
				default: begin
					drop_s2  <= 1'b0;
					bytes_s2 <= '0;
				end
			endcase
		end
	end

	assign done           = done_s2;
	assign bytes_stored   = bytes_s2;
	assign byte_dropped   = drop_s2;
	assign start_transfer = start_s2;
	assign run_start      = rstart_s2;
	assign run_length     = rlen_s2;
	assign read_data      = rd_ok_s2 ? ram_rdata : '0;

endmodule

FILE: rtl/core/tfc_byte_ram.sv
module tfc_byte_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/tfc_ring_ctrl.sv
module tfc_ring_ctrl #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tfc_pkg::ctrl_cmd_t cmd,
	output tfc_pkg::ctrl_res_t res,
	output logic               we,
	output logic [AW-1:0]      waddr,
	output logic [7:0]         wdata
);

	import tfc_pkg::*;

	localparam logic [AW:0] DEPTH_W = (AW+1)'(DEPTH);

	logic [AW-1:0] wp_q, rp_q, pend_q;
	logic          tbusy_q, drop_q;

	logic [AW:0]   fill;
	logic          room, push, fin_op, store, try_go, go;
	logic [AW-1:0] wp_n, rp_e, pend_n;
	logic          tb_e, drop_n;
	logic [AW:0]   cnt;
	logic [AW+9:0] rs_ext;
	logic [AW+10:0] cnt_ext;

	always_comb begin
		push   = cmd.step && (cmd.op == OP_PUSH);
		fin_op = cmd.step && (cmd.op == OP_DONE);

		if (wp_q >= rp_q) begin
			fill = {1'b0, wp_q} - {1'b0, rp_q};
		end else begin
			fill = {1'b0, wp_q} + DEPTH_W - {1'b0, rp_q};
		end
		room  = fill < (DEPTH_W - 1'b1);
		store = push && !drop_q && room;

		wp_n = wp_q;
		if (store) begin
			wp_n = (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
		end

		drop_n = drop_q;
		if (push) begin
			if (cmd.eos && cmd.last) begin
				drop_n = 1'b0;
			end else if (!store) begin
				drop_n = 1'b1;
			end
		end

		// done retires the issued run before a new one is tried
		rp_e   = fin_op ? pend_q : rp_q;
		tb_e   = fin_op ? 1'b0 : tbusy_q;
		try_go = (push && cmd.last && cmd.eos) || fin_op;
		go     = try_go && !tb_e && (wp_n != rp_e);

		if (wp_n > rp_e) begin
			cnt    = {1'b0, wp_n} - {1'b0, rp_e};
			pend_n = wp_n;
		end else begin
			cnt    = DEPTH_W - {1'b0, rp_e};
			pend_n = '0;
		end

		rs_ext  = {10'b0, rp_e};
		cnt_ext = {10'b0, cnt};

		res.stored     = store;
		res.start      = go;
		res.run_start  = rs_ext[9:0];
		res.run_length = cnt_ext[9:0];
	end

	assign we    = store;
	assign waddr = wp_q;
	assign wdata = cmd.ch;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			pend_q  <= '0;
			tbusy_q <= 1'b0;
			drop_q  <= 1'b0;
		end else begin
			wp_q   <= wp_n;
			drop_q <= drop_n;
			if (fin_op) begin
				rp_q <= rp_e;
			end
			// a done clears busy unless a new run goes out at once
			if (fin_op || go) begin
				tbusy_q <= go;
			end
			if (go) begin
				pend_q <= pend_n;
			end
		end
	end

endmodule

FILE: rtl/core/tfc_checker.sv
module tfc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] operation,
	input logic [7:0] data_byte,
	input logic       end_of_string,
	input logic [9:0] read_index,
	input logic       done,
	input logic [1:0] bytes_stored,
	input logic       byte_dropped,
	input logic       start_transfer,
	input logic [9:0] run_start,
	input logic [9:0] run_length,
	input logic [7:0] read_data,
	input logic       cfg_we,
	input logic       cfg_wdata
);

	// the extra CR/LF step never stretches: busy always falls right after it rises
	a_busy_short: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("busy held for more than one cycle");

	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> $past(start && !busy))
		else $error("busy without a preceding command transfer");

	a_done_has_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(start && !busy, 2) || $past(busy, 2)))
		else $error("result without a matching command");

	a_cmd_gets_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 (done || $past(busy)))
		else $error("command transfer produced no result");

	a_run_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && start_transfer) |-> (run_length != 10'd0 || run_start == 10'd0))
		else $error("empty transfer run issued");

endmodule

bind tx_ring_fifo_crlf_chunker_core tfc_checker u_tfc_checker (.*);

FILE: dv/tx_ring_fifo_crlf_chunker_core_tb.sv
`timescale 1ns / 100ps

module tx_ring_fifo_crlf_chunker_core_tb;
	import tfc_pkg::*;

	localparam int DEPTH = 1024;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [1:0] OP_SPARE = 2'd3;

	typedef struct {
		logic [1:0] op;
		logic [7:0] data;
		logic       eos;
		logic [9:0] idx;
		bit         wait_drain;
	} cmd_t;

	typedef struct packed {
		logic [1:0] stored;
		logic       dropped;
		logic       run_go;
		logic [9:0] run_first;
		logic [9:0] run_len;
		logic [7:0] rdata;
	} xfer_res_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	logic [1:0] operation = OP_PUSH;
	logic [7:0] data_byte = 8'h00;
	logic       end_of_string = 1'b0;
	logic [9:0] read_index = 10'd0;
	logic       done;
	logic [1:0] bytes_stored;
	logic       byte_dropped;
	logic       start_transfer;
	logic [9:0] run_start;
	logic [9:0] run_length;
	logic [7:0] read_data;
	logic       cfg_we = 1'b0;
	logic       cfg_wdata = 1'b1;

	tx_ring_fifo_crlf_chunker_core #(
		.FIFO_DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.data_byte(data_byte),
		.end_of_string(end_of_string),
		.read_index(read_index),
		.done(done),
		.bytes_stored(bytes_stored),
		.byte_dropped(byte_dropped),
		.start_transfer(start_transfer),
		.run_start(run_start),
		.run_length(run_length),
		.read_data(read_data),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #2 clk = ~clk;

	// shadow of the ring and its control
	logic [7:0] ring_mem [0:DEPTH-1];
	bit         ring_written [0:DEPTH-1];
	int         ring_wp = 0;
	int         ring_rp = 0;
	int         ring_pend = 0;
	bit         ring_xfer = 1'b0;
	bit         ring_drop = 1'b0;
	bit         lf_exp = 1'b1;

	cmd_t       cmd_q [$];
	xfer_res_t  result_q [$];
	cmd_t       cur_cmd;
	bit         cmd_live = 1'b0;
	int         gap_left = 0;
	int         burst_left = 0;
	int         errors = 0;
	int unsigned cycle_count = 0;
	xfer_res_t  want;

	function automatic bit ring_put(logic [7:0] b);
		int fill;
		fill = (ring_wp + DEPTH - ring_rp) % DEPTH;
		if (ring_drop || fill >= DEPTH - 1) begin
			ring_drop = 1'b1;
			return 1'b0;
		end
		ring_mem[ring_wp] = b;
		ring_written[ring_wp] = 1'b1;
		ring_wp = (ring_wp + 1) % DEPTH;
		return 1'b1;
	endfunction

	function automatic void try_run(inout xfer_res_t r);
		int cnt;
		if (ring_xfer || ring_wp == ring_rp)
			return;
		// a run never wraps: clip at the end of the buffer
		cnt = (ring_wp > ring_rp) ? ring_wp - ring_rp : DEPTH - ring_rp;
		ring_pend = (ring_rp + cnt) % DEPTH;
		ring_xfer = 1'b1;
		r.run_go = 1'b1;
		r.run_first = 10'(ring_rp);
		r.run_len = 10'(cnt);
	endfunction

	function automatic xfer_res_t ring_model_step(cmd_t c);
		xfer_res_t r;
		int n;
		bit lost;
		r = '0;
		n = 0;
		lost = 1'b0;
		case (c.op)
			OP_PUSH: begin
				if (lf_exp && c.data == CH_LF) begin
					if (ring_put(CH_CR)) begin
						n++;
						if (ring_put(CH_LF))
							n++;
						else
							lost = 1'b1;
					end else begin
						lost = 1'b1;
					end
				end else if (ring_put(c.data)) begin
					n++;
				end else begin
					lost = 1'b1;
				end
				r.stored = 2'(n);
				r.dropped = lost;
				if (c.eos) begin
					ring_drop = 1'b0;
					try_run(r);
				end
			end
			OP_DONE: begin
				ring_rp = ring_pend;
				ring_xfer = 1'b0;
				try_run(r);
			end
			OP_READ: r.rdata = ring_mem[c.idx];
			default: ;
		endcase
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			burst_left = $urandom_range(20, 60);
			return 0;
		end
		if (r < 50)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	task automatic load_next();
		cur_cmd = cmd_q.pop_front();
		operation <= cur_cmd.op;
		data_byte <= cur_cmd.data;
		end_of_string <= cur_cmd.eos;
		read_index <= cur_cmd.idx;
		start <= 1'b1;
		cmd_live = 1'b1;
	endtask

	// command driver
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
			cmd_live = 1'b0;
		end else if (start && !busy) begin
			result_q.push_back(ring_model_step(cur_cmd));
			gap_left = pick_gap();
			if (gap_left == 0 && cmd_q.size() != 0 && !cmd_q[0].wait_drain) begin
				load_next();
			end else begin
				start <= 1'b0;
				cmd_live = 1'b0;
			end
		end else if (!start) begin
			if (gap_left != 0)
				gap_left--;
			else if (cmd_q.size() != 0 && (!cmd_q[0].wait_drain || result_q.size() == 0))
				load_next();
		end
	end

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0d, actual %0d", name, exp_v, act_v);
			errors++;
		end
	endtask

	// result monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (result_q.size() == 0) begin
				$error("result with no command outstanding");
				errors++;
			end else begin
				want = result_q.pop_front();
				check_field("bytes_stored", 32'(want.stored), 32'(bytes_stored));
				check_field("byte_dropped", 32'(want.dropped), 32'(byte_dropped));
				check_field("start_transfer", 32'(want.run_go), 32'(start_transfer));
				check_field("run_start", 32'(want.run_first), 32'(run_start));
				check_field("run_length", 32'(want.run_len), 32'(run_length));
				check_field("read_data", 32'(want.rdata), 32'(read_data));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic logic [9:0] rand_idx();
		return 10'($urandom_range(0, DEPTH - 1));
	endfunction

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == CH_LF);
		return b;
	endfunction

	task automatic queue_cmd(logic [1:0] op, logic [7:0] d, logic e, logic [9:0] i,
			bit w = 1'b0);
		cmd_t c;
		c.op = op;
		c.data = d;
		c.eos = e;
		c.idx = i;
		c.wait_drain = w || ($urandom_range(0, 99) == 0);
		cmd_q.push_back(c);
	endtask

	task automatic wait_quiet();
		do
			@(posedge clk);
		while (cmd_q.size() != 0 || cmd_live || result_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_lf(bit v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		lf_exp = v;
	endtask

	task automatic gen_mixed(int n, int done_pct);
		int readable [$];
		int count;
		int r;
		int len;
		logic [7:0] b;
		for (int k = 0; k < DEPTH; k++)
			if (ring_written[k])
				readable.push_back(k);
		if (ring_written[0])
			queue_cmd(OP_READ, 8'($urandom_range(0, 255)), 1'($urandom), 10'd0);
		if (ring_written[DEPTH-1])
			queue_cmd(OP_READ, 8'($urandom_range(0, 255)), 1'($urandom), 10'(DEPTH - 1));
		count = 0;
		while (count < n) begin
			r = $urandom_range(0, 99);
			if (r < 60) begin
				len = $urandom_range(1, 10);
				for (int j = 0; j < len; j++) begin
					b = ($urandom_range(0, 99) < 12) ? CH_LF : 8'($urandom_range(0, 255));
					// now and then the string is left open and runs into the next one
					queue_cmd(OP_PUSH, b, j == len - 1 && $urandom_range(0, 19) != 0,
						rand_idx());
				end
				count += len;
			end else begin
				if (r < 60 + done_pct)
					queue_cmd(OP_DONE, 8'($urandom_range(0, 255)), 1'($urandom), rand_idx());
				else if (r < 93 && readable.size() != 0)
					queue_cmd(OP_READ, 8'($urandom_range(0, 255)), 1'($urandom),
						10'(readable[$urandom_range(0, readable.size() - 1)]));
				else if (r < 97 || readable.size() == 0)
					queue_cmd(OP_SPARE, 8'($urandom_range(0, 255)), 1'($urandom), rand_idx());
				else
					queue_cmd(OP_PUSH, 8'($urandom_range(0, 255)), 1'($urandom), rand_idx());
				count++;
			end
		end
		// close any open string so the next phase starts clean
		queue_cmd(OP_PUSH, plain_byte(), 1'b1, rand_idx());
	endtask

	// fill to one free slot with no completions, then hit the full cases
	task automatic gen_fill();
		int f;
		logic [7:0] b;
		f = (ring_wp + DEPTH - ring_rp) % DEPTH;
		while (f < DEPTH - 2) begin
			if (f == DEPTH - 3 || $urandom_range(0, 99) >= 65)
				b = plain_byte();
			else
				b = CH_LF;
			queue_cmd(OP_PUSH, b, $urandom_range(0, 99) < 15, rand_idx());
			f += (b == CH_LF) ? 2 : 1;
		end
		queue_cmd(OP_PUSH, CH_LF, 1'b0, rand_idx());
		queue_cmd(OP_PUSH, plain_byte(), 1'b0, rand_idx());
		queue_cmd(OP_PUSH, CH_LF, 1'b1, rand_idx());
		queue_cmd(OP_PUSH, plain_byte(), 1'b1, rand_idx());
		queue_cmd(OP_PUSH, CH_LF, 1'b1, rand_idx());
		queue_cmd(OP_DONE, 8'($urandom_range(0, 255)), 1'($urandom), rand_idx(), 1'b1);
		repeat (3)
			queue_cmd(OP_DONE, 8'($urandom_range(0, 255)), 1'($urandom), rand_idx());
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle completion on an empty ring, then an unused opcode
		queue_cmd(OP_DONE, 8'h00, 1'b0, 10'd0);
		queue_cmd(OP_SPARE, 8'hFF, 1'b1, 10'h3FF);
		queue_cmd(OP_PUSH, 8'h41, 1'b0, 10'h3FF);
		queue_cmd(OP_PUSH, CH_LF, 1'b0, 10'd0);
		queue_cmd(OP_PUSH, 8'hFF, 1'b1, 10'd0);
		// end of string while a transfer is running
		queue_cmd(OP_PUSH, 8'h00, 1'b1, 10'h3FF);
		for (int k = 0; k < 5; k++)
			queue_cmd(OP_READ, 8'($urandom_range(0, 255)), 1'($urandom), 10'(k));
		queue_cmd(OP_DONE, 8'hFF, 1'b1, 10'h3FF);
		queue_cmd(OP_DONE, 8'h00, 1'b0, 10'd0);
		queue_cmd(OP_DONE, 8'hA5, 1'b1, 10'h155);
		queue_cmd(OP_PUSH, CH_LF, 1'b1, 10'h2AA);
		queue_cmd(OP_PUSH, CH_CR, 1'b1, 10'h155);
		queue_cmd(OP_DONE, 8'h5A, 1'b0, 10'h2AA, 1'b1);
		queue_cmd(OP_DONE, 8'h00, 1'b0, 10'd0);
		wait_quiet();

		gen_mixed(80, 20);
		wait_quiet();
		set_lf(1'b0);
		gen_mixed(60, 5);
		wait_quiet();
		set_lf(1'b1);
		gen_fill();
		wait_quiet();
		gen_mixed(60, 20);
		wait_quiet();
		set_lf(1'b0);
		gen_mixed(30, 15);
		wait_quiet();
		set_lf(1'b1);
		gen_mixed(20, 20);
		wait_quiet();
		repeat (10) @(posedge clk);

		if (errors == 0 && result_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/tfc_pkg.sv
rtl/core/tfc_byte_ram.sv
rtl/core/tfc_ring_ctrl.sv
rtl/core/tx_ring_fifo_crlf_chunker_core.sv
rtl/core/tfc_checker.sv
dv/tx_ring_fifo_crlf_chunker_core_tb.sv
